[sv/sha1_pkg.sv]
// Shared types, constants and round constants for the SHA-1 byte stream hasher.
package sha1_pkg;

  localparam int WordW     = 32;
  localparam int NumWords  = 16;
  localparam int BlkW      = NumWords * WordW;
  localparam int NumChain  = 5;

  typedef logic [WordW-1:0] word_t;
  typedef word_t [NumChain-1:0] chain_t;

  // Initial chaining values, element 0 last in the concatenation
  localparam chain_t IvInit = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam logic [7:0] PadByte   = 8'h80;
  localparam logic [7:0] ZeroByte  = 8'h00;
  localparam logic [5:0] FillLast  = 6'd63;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [6:0] LastRound = 7'd79;

  localparam logic OpAbsorb = 1'b0;
  localparam logic OpFinish = 1'b1;

  // Control of the message buffer: load shifts one byte in, sched advances the schedule
  typedef struct packed {
    logic       load;
    logic       sched;
    logic [7:0] byte_in;
  } buf_ctl_t;

  // Control of the round unit
  typedef struct packed {
    logic       init;
    logic       step;
    logic [6:0] round;
  } rnd_ctl_t;

  function automatic word_t round_const(logic [6:0] r);
    word_t k;
    if (r < 7'd20) begin
      k = 32'h5A827999;
    end else if (r < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (r < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

endpackage

[sv/sha1_msg_buf.sv]
// Message block buffer: byte-wise big-endian loading and the 16-word schedule ring.
module sha1_msg_buf (
  input  logic              clk,
  input  sha1_pkg::buf_ctl_t ctl,
  output sha1_pkg::word_t    w_cur
);
  import sha1_pkg::*;

  logic [BlkW-1:0] blk;
  word_t           w0, w2, w8, w13, w_mix, w_new;

  // Word j of the ring sits at blk[BlkW-1-WordW*j -: WordW]; word 0 is the current W
  assign w0    = blk[BlkW-1               -: WordW];
  assign w2    = blk[BlkW-1 - 2 * WordW   -: WordW];
  assign w8    = blk[BlkW-1 - 8 * WordW   -: WordW];
  assign w13   = blk[BlkW-1 - 13 * WordW  -: WordW];
  assign w_mix = w13 ^ w8 ^ w2 ^ w0;
  assign w_new = {w_mix[WordW-2:0], w_mix[WordW-1]};
  assign w_cur = w0;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      blk <= {blk[BlkW-9:0], ctl.byte_in};
    end else if (ctl.sched) begin
      blk <= {blk[BlkW-WordW-1:0], w_new};
    end
  end

endmodule

[sv/sha1_round.sv]
// SHA-1 round unit: working variables a..e and one round of compression per step.
module sha1_round (
  input  logic              clk,
  input  sha1_pkg::rnd_ctl_t ctl,
  input  sha1_pkg::chain_t   chain_in,
  input  sha1_pkg::word_t    w_in,
  output sha1_pkg::chain_t   work
);
  import sha1_pkg::*;

  word_t a, b, c, d, e;
  word_t f, t, k;

  always_comb begin
    if (ctl.round < 7'd20) begin
      f = d ^ (b & (c ^ d));
    end else if (ctl.round >= 7'd40 && ctl.round < 7'd60) begin
      f = (b & c) | (d & (b | c));
    end else begin
      f = b ^ c ^ d;
    end
    k = round_const(ctl.round);
    t = {a[WordW-6:0], a[WordW-1:WordW-5]} + f + e + k + w_in;
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      a <= chain_in[0];
      b <= chain_in[1];
      c <= chain_in[2];
      d <= chain_in[3];
      e <= chain_in[4];
    end else if (ctl.step) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[WordW-1:2]};
      b <= a;
      a <= t;
    end
  end

  assign work = {e, d, c, b, a};

endmodule

[sv/sha1_byte_stream_hash.sv]
// Top level of the SHA-1 byte stream hasher: sequencer, byte count, chaining words, output.
//
// Input channel (in_valid/in_ready): one beat per item. operation 0 absorbs data_byte,
// operation 1 finishes the message. Output channel (out_valid/out_ready): one beat per
// finish, carrying the five digest words, digest_word0 first in big-endian order.
// An absorb beat that fills a block, every 64th byte, also runs the compression: the
// rounds of the shared round unit (one round per cycle), then a fold of the result
// into the chaining words.
// A finish shifts in the 0x80 pad byte, zero bytes one per cycle outside a compression up
// to byte 56, and the eight bytes of the bit length, then compresses; when 56 or more bytes
// of the last block were in use, the padding spills into a further block and compression.
// in_ready is high only while the sequencer is idle; the block takes one item at a time.
// The digest sits in its own output register, so absorbing of the next message goes on
// while a digest waits; a second finish holds in the last step until the receiver takes
// the earlier digest. After each finish the chaining words return to the initial values
// and the byte count to zero. Synchronous reset does the same and drops any pending
// digest; the message buffer needs no reset, since every byte is written before use.
module sha1_byte_stream_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word0,
  output logic [31:0] digest_word1,
  output logic [31:0] digest_word2,
  output logic [31:0] digest_word3,
  output logic [31:0] digest_word4
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_ROUND,
    S_ADD,
    S_DONE
  } state_t;

  state_t      state, ret_state;
  logic [6:0]  round_cnt;
  logic [5:0]  fill;        // bytes in the current block
  logic [63:0] byte_total;
  logic [63:0] len_sh;      // bit length, shifted out a byte at a time
  chain_t      chain;
  chain_t      digest;
  chain_t      work;
  word_t       w_cur;
  buf_ctl_t    buf_ctl;
  rnd_ctl_t    rnd_ctl;
  logic        accept;
  logic        block_full;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Byte path into the message buffer
  always_comb begin
    buf_ctl.load    = 1'b0;
    buf_ctl.sched   = (state == S_ROUND);
    buf_ctl.byte_in = ZeroByte;
    unique case (state)
      S_IDLE: begin
        buf_ctl.load    = accept;
        buf_ctl.byte_in = (operation == OpFinish) ? PadByte : data_byte;
      end
      S_PAD: begin
        buf_ctl.load = (fill != LenStart);
      end
      S_LEN: begin
        buf_ctl.load    = 1'b1;
        buf_ctl.byte_in = len_sh[63:56];
      end
      default: begin
        buf_ctl.load = 1'b0;
      end
    endcase
  end

  // The byte that fills the block starts a compression
  assign block_full    = buf_ctl.load && (fill == FillLast);
  assign rnd_ctl.init  = block_full;
  assign rnd_ctl.step  = (state == S_ROUND);
  assign rnd_ctl.round = round_cnt;

  sha1_msg_buf u_buf (
    .clk   (clk),
    .ctl   (buf_ctl),
    .w_cur (w_cur)
  );

  sha1_round u_round (
    .clk      (clk),
    .ctl      (rnd_ctl),
    .chain_in (chain),
    .w_in     (w_cur),
    .work     (work)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret_state  <= S_IDLE;
      round_cnt  <= '0;
      fill       <= '0;
      byte_total <= '0;
      chain      <= IvInit;
      out_valid  <= 1'b0;
    end else begin
      // drop the digest once taken, unless a new one takes its place below
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (buf_ctl.load) begin
        fill <= fill + 6'd1;
      end
      if (block_full) begin
        round_cnt <= '0;
        state     <= S_ROUND;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (operation == OpAbsorb) begin
              byte_total <= byte_total + 64'd1;
              ret_state  <= S_IDLE;
            end else begin
              len_sh    <= {byte_total[60:0], 3'b000};
              ret_state <= S_PAD;
              if (!block_full) begin
                state <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          if (fill == LenStart) begin
            state <= S_LEN;
          end else begin
            ret_state <= S_PAD;
          end
        end
        S_LEN: begin
          len_sh    <= {len_sh[55:0], ZeroByte};
          ret_state <= S_DONE;
        end
        S_ROUND: begin
          round_cnt <= round_cnt + 7'd1;
          if (round_cnt == LastRound) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int i = 0; i < NumChain; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          state <= ret_state;
        end
        S_DONE: begin
          // hold until the previous digest has left
          if (!out_valid || out_ready) begin
            digest     <= chain;
            out_valid  <= 1'b1;
            chain      <= IvInit;
            byte_total <= '0;
            fill       <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign digest_word0 = digest[0];
  assign digest_word1 = digest[1];
  assign digest_word2 = digest[2];
  assign digest_word3 = digest[3];
  assign digest_word4 = digest[4];

endmodule
